[sv/gamepad_direction_and_rapid_fire_macros.svh]
// ============================================================================
// gamepad_direction_and_rapid_fire_macros.svh
// Assertion macros for the gamepad direction and rapid fire block.
// ============================================================================
`ifndef GAMEPAD_DIRECTION_AND_RAPID_FIRE_MACROS_SVH
`define GAMEPAD_DIRECTION_AND_RAPID_FIRE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define GDRF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define GDRF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`else

`define GDRF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)
`define GDRF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

[sv/gdrf_pkg.sv]
// ============================================================================
// gdrf_pkg
// Constants, register codes and stick decode functions for the pad decoder.
// ============================================================================
`default_nettype none

package gdrf_pkg;

	localparam int PAD_COUNT    = 4;
	localparam int BUTTON_COUNT = 11;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEAD_ZONE   = 3'd0,
		CFG_RAPID_SKIP  = 3'd1,
		CFG_FIRE_LOAD   = 3'd2,
		CFG_ZAPPER_MODE = 3'd3,
		CFG_DISK_SYSTEM = 3'd4
	} cfg_index_t;

	localparam logic [6:0] DEAD_ZONE_RST  = 7'd50;
	localparam logic [7:0] RAPID_SKIP_RST = 8'd2;
	localparam logic [7:0] FIRE_LOAD_RST  = 8'd2;

	// tan(67.5 deg) in Q16
	localparam logic [26:0] TAN_Q16 = 27'd158218;

	// logical button bit positions
	localparam int LB_B       = 0;
	localparam int LB_A       = 1;
	localparam int LB_RAPID_B = 2;
	localparam int LB_RAPID_A = 3;
	localparam int LB_SELECT  = 4;
	localparam int LB_START   = 5;
	localparam int LB_UP      = 6;
	localparam int LB_DOWN    = 7;
	localparam int LB_LEFT    = 8;
	localparam int LB_RIGHT   = 9;
	localparam int LB_SPECIAL = 10;

	// NES button bit positions
	localparam int NES_A      = 0;
	localparam int NES_B      = 1;
	localparam int NES_SELECT = 2;
	localparam int NES_START  = 3;
	localparam int NES_UP     = 4;
	localparam int NES_DOWN   = 5;
	localparam int NES_LEFT   = 6;
	localparam int NES_RIGHT  = 7;

	typedef logic [BUTTON_COUNT-1:0] lbtn_t;
	typedef logic [7:0] nes_t;

	// -K <= num/den < K, den nonzero, by cross multiplication
	function automatic logic ratio_inside(logic signed [7:0] num, logic signed [7:0] den);
		logic signed [8:0]  sn;
		logic [7:0]         ad;
		logic signed [26:0] lhs;
		logic signed [26:0] lim;
		sn  = den[7] ? -(9'(num)) : 9'(num);
		ad  = den[7] ? ($unsigned(~den) + 8'd1) : $unsigned(den);
		lhs = 27'(sn) <<< 16;
		lim = $signed(TAN_Q16 * {19'd0, ad});
		return (lhs >= -lim) && (lhs < lim);
	endfunction

	function automatic nes_t stick_dir(logic signed [7:0] x, logic signed [7:0] y,
		logic [6:0] dz);
		logic signed [16:0] xs;
		logic signed [16:0] ys;
		logic signed [16:0] dzs;
		logic signed [16:0] mag;
		logic signed [16:0] lim;
		nes_t               j;
		xs  = 17'(x);
		ys  = 17'(y);
		dzs = $signed({10'd0, dz});
		mag = xs * xs + ys * ys;
		lim = dzs * dzs;
		j   = '0;
		if (mag > lim) begin
			if (y == 8'sd0) begin
				if (x > 8'sd0) j[NES_RIGHT] = 1'b1;
				if (x < 8'sd0) j[NES_LEFT]  = 1'b1;
			end else if (x == 8'sd0) begin
				if (y > 8'sd0) j[NES_UP]   = 1'b1;
				if (y < 8'sd0) j[NES_DOWN] = 1'b1;
			end else begin
				if (ratio_inside(y, x)) begin
					if (!x[7]) j[NES_RIGHT] = 1'b1;
					else       j[NES_LEFT]  = 1'b1;
				end
				if (ratio_inside(x, y)) begin
					if (!y[7]) j[NES_UP]   = 1'b1;
					else       j[NES_DOWN] = 1'b1;
				end
			end
		end
		return j;
	endfunction

endpackage

`default_nettype wire

[sv/gamepad_direction_and_rapid_fire.sv]
// ============================================================================
// gamepad_direction_and_rapid_fire
// Pad poll decoder: stick directions, NES button bits, rapid fire, coin/disk.
// ============================================================================
// Path: a poll accepted is registered in the input stage, then in the result
//   register, and waits in the input stage while a held result stalls it.
// Throughput: one poll per cycle while no result is held; the counter and frame
//   phase update is a single short pass from the input stage to the result register.
// Reset: arst_n clears valids, rapid counters and frame phase, and loads the
//   register defaults (dead zone 50, skip 2, press 2, zapper off, coin mode).
`default_nettype none

`include "gamepad_direction_and_rapid_fire_macros.svh"

module gamepad_direction_and_rapid_fire (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write port
	input  wire logic                            cfg_we,
	input  wire logic [gdrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gdrf_pkg::CFG_DATA_W-1:0] cfg_data,
	// poll channel
	input  wire logic                            poll_valid,
	output logic                                 poll_stall,
	input  wire logic [1:0]                      pad_index,
	input  wire logic                            new_frame,
	input  wire logic signed [7:0]               main_stick_x,
	input  wire logic signed [7:0]               main_stick_y,
	input  wire logic signed [7:0]               aux_stick_x,
	input  wire logic signed [7:0]               aux_stick_y,
	input  wire logic [gdrf_pkg::BUTTON_COUNT-1:0] logical_buttons,
	// result channel
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic [7:0]                           nes_buttons,
	output logic                                 disk_switch_request,
	output logic                                 coin_request
);

	import gdrf_pkg::*;

	// ---------------------------------------------------------------- config
	logic [6:0] dead_zone_q;
	logic [7:0] rapid_skip_q;
	logic [7:0] fire_load_q;
	logic       zapper_mode_q;
	logic       disk_system_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q   <= DEAD_ZONE_RST;
			rapid_skip_q  <= RAPID_SKIP_RST;
			fire_load_q   <= FIRE_LOAD_RST;
			zapper_mode_q <= 1'b0;
			disk_system_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEAD_ZONE:   dead_zone_q   <= cfg_data[6:0];
				CFG_RAPID_SKIP:  rapid_skip_q  <= cfg_data;
				CFG_FIRE_LOAD:   fire_load_q   <= cfg_data;
				CFG_ZAPPER_MODE: zapper_mode_q <= cfg_data[0];
				CFG_DISK_SYSTEM: disk_system_q <= cfg_data[0];
				default: ;      // unmapped index: dropped
			endcase
		end
	end

	// ---------------------------------------------------------------- handshake
	// The input stage moves into the result register whenever that register is
	// empty or being drained this cycle. The input stage takes a new beat when
	// it is empty or moving on, so a held result does not block one poll.
	logic valid_s1;
	logic result_valid_q;
	logic result_hold;
	logic adv_s1;

	assign result_hold = result_valid_q && result_stall;
	assign adv_s1      = valid_s1 && !result_hold;
	assign poll_stall  = valid_s1 && result_hold;

	// ---------------------------------------------------------------- input stage
	logic [1:0]        pad_s1;
	logic              new_frame_s1;
	logic signed [7:0] msx_s1;
	logic signed [7:0] msy_s1;
	logic signed [7:0] asx_s1;
	logic signed [7:0] asy_s1;
	lbtn_t             btn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!poll_stall) begin
			valid_s1 <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_valid && !poll_stall) begin
			pad_s1       <= pad_index;
			new_frame_s1 <= new_frame;
			msx_s1       <= main_stick_x;
			msy_s1       <= main_stick_y;
			asx_s1       <= aux_stick_x;
			asy_s1       <= aux_stick_y;
			btn_s1       <= logical_buttons;
		end
	end

	// ---------------------------------------------------------------- frame phase
	// Phase advances before the poll is decoded; the fire test sees the new value.
	// A skip of zero behaves like one: the wrap compare always hits.
	logic [7:0] frame_phase_q;
	logic [7:0] phase_next;
	logic [8:0] phase_inc;
	logic       phase_zero;

	always_comb begin
		phase_inc = {1'b0, frame_phase_q} + 9'd1;
		if (new_frame_s1) begin
			phase_next = (phase_inc >= {1'b0, rapid_skip_q}) ? 8'd0 : phase_inc[7:0];
		end else begin
			phase_next = frame_phase_q;
		end
		phase_zero = (phase_next == 8'd0);
	end

	// ---------------------------------------------------------------- rapid counters
	// Per pad: load from fire_load if the rapid button is held (not in zapper
	// mode), then fire and count down on a zero phase. Pads past PAD_COUNT
	// never match any counter.
	logic [7:0]           rapid_a_count_q [PAD_COUNT];
	logic [7:0]           rapid_b_count_q [PAD_COUNT];
	logic [7:0]           a_next [PAD_COUNT];
	logic [7:0]           b_next [PAD_COUNT];
	logic [PAD_COUNT-1:0] pad_hit;
	logic [PAD_COUNT-1:0] fire_a;
	logic [PAD_COUNT-1:0] fire_b;

	always_comb begin
		logic [7:0] a_ld;
		logic [7:0] b_ld;
		for (int i = 0; i < PAD_COUNT; i++) begin
			pad_hit[i] = (32'(pad_s1) == 32'(i));
			a_ld = (pad_hit[i] && !zapper_mode_q && btn_s1[LB_RAPID_A]) ?
				fire_load_q : rapid_a_count_q[i];
			b_ld = (pad_hit[i] && !zapper_mode_q && btn_s1[LB_RAPID_B]) ?
				fire_load_q : rapid_b_count_q[i];
			fire_a[i] = pad_hit[i] && phase_zero && (a_ld != 8'd0);
			fire_b[i] = pad_hit[i] && phase_zero && (b_ld != 8'd0);
			a_next[i] = fire_a[i] ? (a_ld - 8'd1) : a_ld;
			b_next[i] = fire_b[i] ? (b_ld - 8'd1) : b_ld;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_phase_q <= 8'd0;
			for (int i = 0; i < PAD_COUNT; i++) begin
				rapid_a_count_q[i] <= 8'd0;
				rapid_b_count_q[i] <= 8'd0;
			end
		end else if (adv_s1) begin
			frame_phase_q <= phase_next;
			for (int i = 0; i < PAD_COUNT; i++) begin
				rapid_a_count_q[i] <= a_next[i];
				rapid_b_count_q[i] <= b_next[i];
			end
		end
	end

	// ---------------------------------------------------------------- decode
	nes_t buttons_d;
	logic special_d;

	always_comb begin
		buttons_d = stick_dir(msx_s1, msy_s1, dead_zone_q)
			| stick_dir(asx_s1, asy_s1, dead_zone_q);
		special_d = 1'b0;
		if (!zapper_mode_q) begin
			buttons_d[NES_B]     = buttons_d[NES_B]     | btn_s1[LB_B];
			buttons_d[NES_A]     = buttons_d[NES_A]     | btn_s1[LB_A];
			buttons_d[NES_UP]    = buttons_d[NES_UP]    | btn_s1[LB_UP];
			buttons_d[NES_DOWN]  = buttons_d[NES_DOWN]  | btn_s1[LB_DOWN];
			buttons_d[NES_LEFT]  = buttons_d[NES_LEFT]  | btn_s1[LB_LEFT];
			buttons_d[NES_RIGHT] = buttons_d[NES_RIGHT] | btn_s1[LB_RIGHT];
			special_d            = btn_s1[LB_SPECIAL];
		end
		// start and select pass in zapper mode too
		buttons_d[NES_SELECT] = buttons_d[NES_SELECT] | btn_s1[LB_SELECT];
		buttons_d[NES_START]  = buttons_d[NES_START]  | btn_s1[LB_START];
		// loaded counters fire even in zapper mode
		buttons_d[NES_A] = buttons_d[NES_A] | (|fire_a);
		buttons_d[NES_B] = buttons_d[NES_B] | (|fire_b);
	end

	// ---------------------------------------------------------------- result register
	nes_t nes_buttons_q;
	logic disk_req_q;
	logic coin_req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (!result_hold) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			nes_buttons_q <= buttons_d;
			disk_req_q    <= special_d && disk_system_q;
			coin_req_q    <= special_d && !disk_system_q;
		end
	end

	assign result_valid        = result_valid_q;
	assign nes_buttons         = nes_buttons_q;
	assign disk_switch_request = disk_req_q;
	assign coin_request        = coin_req_q;

	// ---------------------------------------------------------------- assertions
	`GDRF_ASSERT_IMP(a_stall_only_full, clk, arst_n, poll_stall,
		valid_s1 && result_valid_q && result_stall, "poll stalled without a full pipe")
	`GDRF_ASSERT_NXT(a_s1_moves_on, clk, arst_n, valid_s1 && !result_hold,
		result_valid_q, "input stage beat lost on its way to the result register")
	`GDRF_ASSERT_IMP(a_req_exclusive, clk, arst_n, result_valid_q,
		!(disk_req_q && coin_req_q), "disk switch and coin requested together")

endmodule

`default_nettype wire
